// ===== rtl/core/dqs_pkg.sv =====
// shared types and constants of the double-ended queue with search
// used by every module of the block except dqs_ram; depends on nothing
package dqs_pkg;

  // store geometry (depth is kept a power of two, so ring indexes wrap naturally)
  localparam int unsigned DEPTH = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ST_W  = 2;

  // stream widths: fields packed from bit 0, padded to whole bytes
  localparam int unsigned S_DATA_W   = ((VAL_W + 7) / 8) * 8;
  localparam int unsigned S_USER_W   = ((OP_W + 7) / 8) * 8;
  localparam int unsigned M_FIELDS_W = 2 * VAL_W + CNT_W + 1 + 1 + ST_W;
  localparam int unsigned M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd6;

  // status codes
  localparam logic [ST_W-1:0] STS_OK        = 2'd0;
  localparam logic [ST_W-1:0] STS_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] STS_UNDERFLOW = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // capture the input beat
    logic exec;      // apply push or pop, set status
    logic scan;      // walk the store comparing entries
    logic rd_front;  // read the front entry
    logic rd_back;   // read the back entry, keep front data
    logic load_out;  // load the result register
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic needs_scan;  // search or remove on a non-empty store
    logic scan_done;   // walk finished this cycle
    logic out_free;    // result register can take a beat
  } dp_sts_t;

endpackage

// ===== rtl/core/double_ended_queue_with_search.sv =====
// top level of the double-ended queue with search: stream ports, controller and datapath
// depends on dqs_pkg, dqs_ctrl, dqs_datapath
//
// Bounded deque of 16 signed 32-bit values in a ring store. Each input beat carries an
// operation in tuser and a value in tdata; every beat gives exactly one result beat with
// front, back, count, empty flag, found flag and status. Items are handled one at a time:
// push, pop and query pass through the exec, front read, back read and done states; search
// and remove on a non-empty store add a scan state that walks the stored entries, since the
// store has a single read port and the walk reads one entry per cycle. A remove shifts
// the later entries during the same walk. A finished result waits in an output register,
// so the next input beat is taken while the result is still stalled.
module double_ended_queue_with_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input beat
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dqs_pkg::S_DATA_W-1:0]    s_axis_tdata,  // item_value
  input  logic [dqs_pkg::S_USER_W-1:0]    s_axis_tuser,  // op
  // result beat
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // front_value, back_value, entry_count, is_empty, found, status, zero pad
  output logic [dqs_pkg::M_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned PAD_W = dqs_pkg::M_DATA_W - dqs_pkg::M_FIELDS_W;

  dqs_pkg::dp_cmd_t cmd;
  dqs_pkg::dp_sts_t sts;

  logic [dqs_pkg::VAL_W-1:0] front_value, back_value;
  logic [dqs_pkg::CNT_W-1:0] entry_count;
  logic                      is_empty, found;
  logic [dqs_pkg::ST_W-1:0]  status;

  dqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dqs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (s_axis_tuser[dqs_pkg::OP_W-1:0]),
    .value_i       (s_axis_tdata[dqs_pkg::VAL_W-1:0]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .front_value_o (front_value),
    .back_value_o  (back_value),
    .entry_count_o (entry_count),
    .is_empty_o    (is_empty),
    .found_o       (found),
    .status_o      (status)
  );

  // result packing, first field in the lowest bits
  assign m_axis_tdata = {{PAD_W{1'b0}}, status, found, is_empty, entry_count,
                         back_value, front_value};

endmodule

// ===== rtl/core/dqs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no package dependency
module dqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dqs_ctrl.sv =====
// controller state machine of the deque: sequences exec, scan, readout and result
// depends on dqs_pkg for the command and status structs
module dqs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  dqs_pkg::dp_sts_t sts_i,
  output dqs_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_RD_FRONT = 3'd3;
  localparam logic [2:0] S_RD_BACK  = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    s_ready_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.needs_scan ? S_SCAN : S_RD_FRONT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_RD_FRONT;
        end
      end
      S_RD_FRONT: begin
        cmd_o.rd_front = 1'b1;
        state_d        = S_RD_BACK;
      end
      S_RD_BACK: begin
        cmd_o.rd_back = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/dqs_datapath.sv =====
// datapath of the deque: ring pointers, store, scan compare and result register
// depends on dqs_pkg and dqs_ram
module dqs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dqs_pkg::dp_cmd_t              cmd_i,
  output dqs_pkg::dp_sts_t              sts_o,
  input  logic [dqs_pkg::OP_W-1:0]      op_i,
  input  logic [dqs_pkg::VAL_W-1:0]     value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dqs_pkg::VAL_W-1:0]     front_value_o,
  output logic [dqs_pkg::VAL_W-1:0]     back_value_o,
  output logic [dqs_pkg::CNT_W-1:0]     entry_count_o,
  output logic                          is_empty_o,
  output logic                          found_o,
  output logic [dqs_pkg::ST_W-1:0]      status_o
);

  // latched item
  logic [dqs_pkg::OP_W-1:0]  op_q;
  logic [dqs_pkg::VAL_W-1:0] val_q;

  // queue state
  logic [dqs_pkg::IDX_W-1:0] head_q, head_d;
  logic [dqs_pkg::CNT_W-1:0] count_q, count_d;
  logic [dqs_pkg::ST_W-1:0]  status_q, status_d;

  // scan state
  logic [dqs_pkg::CNT_W-1:0] rd_off_q;
  logic [dqs_pkg::IDX_W-1:0] cmp_off_q;
  logic                      cmp_vld_q;
  logic                      hit_q;

  // readout
  logic [dqs_pkg::VAL_W-1:0] front_q;

  // result register
  logic                      out_valid_q;
  logic [dqs_pkg::VAL_W-1:0] out_front_q, out_back_q;
  logic [dqs_pkg::CNT_W-1:0] out_count_q;
  logic                      out_empty_q, out_found_q;
  logic [dqs_pkg::ST_W-1:0]  out_status_q;

  // ram ports
  logic                      ram_we, ram_re;
  logic [dqs_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
  logic [dqs_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

  logic is_full, is_empty, issue, match, last_cmp, is_search, is_remove;

  assign is_full   = (count_q == dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
  assign is_empty  = (count_q == '0);
  assign is_search = (op_q == dqs_pkg::OP_SEARCH);
  assign is_remove = (op_q == dqs_pkg::OP_REMOVE);
  assign issue     = (rd_off_q < count_q);
  assign match     = (ram_rdata == val_q);
  assign last_cmp  = ((dqs_pkg::CNT_W'(cmp_off_q) + dqs_pkg::CNT_W'(1)) == count_q);

  assign sts_o.needs_scan = (is_search || is_remove) && !is_empty;
  assign sts_o.scan_done  = cmd_i.scan && cmp_vld_q && ((is_search && match) || last_cmp);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // push and pop updates, shift writes of a remove
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = val_q;
    if (cmd_i.exec) begin
      status_d = dqs_pkg::STS_OK;
      case (op_q)
        dqs_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = dqs_pkg::STS_OVERFLOW;
          end else begin
            head_d    = head_q - dqs_pkg::IDX_W'(1);
            ram_we    = 1'b1;
            ram_waddr = head_q - dqs_pkg::IDX_W'(1);
            count_d   = count_q + dqs_pkg::CNT_W'(1);
          end
        end
        dqs_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = dqs_pkg::STS_OVERFLOW;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_q + count_q[dqs_pkg::IDX_W-1:0];
            count_d   = count_q + dqs_pkg::CNT_W'(1);
          end
        end
        dqs_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            status_d = dqs_pkg::STS_UNDERFLOW;
          end else begin
            head_d  = head_q + dqs_pkg::IDX_W'(1);
            count_d = count_q - dqs_pkg::CNT_W'(1);
          end
        end
        dqs_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            status_d = dqs_pkg::STS_UNDERFLOW;
          end else begin
            count_d = count_q - dqs_pkg::CNT_W'(1);
          end
        end
        default: begin
          status_d = dqs_pkg::STS_OK;
        end
      endcase
    end else if (cmd_i.scan) begin
      // after a removal match every later entry moves one place to the front
      if (cmp_vld_q && hit_q) begin
        ram_we    = 1'b1;
        ram_waddr = head_q + cmp_off_q - dqs_pkg::IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      if (sts_o.scan_done && is_remove && (hit_q || match)) begin
        count_d = count_q - dqs_pkg::CNT_W'(1);
      end
    end
  end

  // read address: scan walk, then front and back
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = head_q;
    if (cmd_i.scan) begin
      ram_re    = issue;
      ram_raddr = head_q + rd_off_q[dqs_pkg::IDX_W-1:0];
    end else if (cmd_i.rd_front) begin
      ram_re    = 1'b1;
      ram_raddr = head_q;
    end else if (cmd_i.rd_back) begin
      ram_re    = 1'b1;
      ram_raddr = head_q + count_q[dqs_pkg::IDX_W-1:0] - dqs_pkg::IDX_W'(1);
    end
  end

  dqs_ram #(
    .WIDTH (dqs_pkg::VAL_W),
    .DEPTH (dqs_pkg::DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      rd_off_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.exec) begin
        rd_off_q  <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= issue;
        if (issue) begin
          rd_off_q <= rd_off_q + dqs_pkg::CNT_W'(1);
        end
        if (cmp_vld_q && match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (cmd_i.latch) begin
      op_q  <= op_i;
      val_q <= value_i;
    end
    if (cmd_i.scan) begin
      cmp_off_q <= rd_off_q[dqs_pkg::IDX_W-1:0];
    end
    if (cmd_i.rd_back) begin
      front_q <= ram_rdata;
    end
    if (cmd_i.load_out) begin
      out_front_q  <= is_empty ? '0 : front_q;
      out_back_q   <= is_empty ? '0 : ram_rdata;
      out_count_q  <= count_q;
      out_empty_q  <= is_empty;
      out_found_q  <= hit_q;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_value_o = out_front_q;
  assign back_value_o  = out_back_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign found_o       = out_found_q;
  assign status_o      = out_status_q;

endmodule

// ===== rtl/core/dqs_checker.sv =====
// port-level checker for the deque, attached to the top level by bind
// depends on dqs_pkg
module dqs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [dqs_pkg::M_DATA_W-1:0] m_axis_tdata
);

  logic       s_beat, m_beat;
  logic [1:0] pend_q;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign m_beat = m_axis_tvalid && m_axis_tready;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (s_beat && !m_beat) begin
      pend_q <= pend_q + 2'd1;
    end else if (m_beat && !s_beat) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // stalled result stays valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // stalled result payload holds
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // no result without an accepted item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result beat without a pending item");

endmodule

bind double_ended_queue_with_search dqs_checker u_dqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
